// ===== sv/gbw_pkg.sv =====
// Shared types and constants for the Gaussian blur window filter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package gbw_pkg;

  localparam int PIX_W           = 8;
  localparam int COEF_W          = 12;
  localparam int COEFF_FRAC_BITS = 12;
  localparam int FW_W            = 11;
  localparam int FH_W            = 13;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 60;
  localparam int OUT_DEPTH       = 8;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Kernel rows 4 down to 0
  localparam logic [4:0][CFG_DATA_W-1:0] KERNEL_RST = {
    60'd0, 60'd0, 60'd69206272, 60'd8594129408, 60'd69206272
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_KERNEL_ROW_0 = 3'd2,
    REG_KERNEL_ROW_1 = 3'd3,
    REG_KERNEL_ROW_2 = 3'd4,
    REG_KERNEL_ROW_3 = 3'd5,
    REG_KERNEL_ROW_4 = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/gaussian_blur_window_filter.sv =====
// Gaussian blur window filter, top level: counters, line store, cell row,
// adder and result queue. Depends on gbw_pkg, gbw_line_bank, gbw_cell,
// gbw_out_fifo.
//
// Pixels enter on the s_axis stream in raster order; tuser=0 marks a frame
// pixel, tuser=1 a drain word. After the last pixel of a frame, send
// RADIUS_TAPS*width+RADIUS_TAPS drain words to flush the remaining outputs.
// Blurred pixels leave on m_axis in raster order, tlast on the final pixel.
// The cfg channel writes geometry and kernel rows; cfg_ready_o is always high.
// A geometry write restarts the frame.
// Throughput: one word per clock while s_axis_tready is high. A pixel word, or
// any word after the frame's last pixel, reads the line store once and shifts
// one column into the row of window cells; drain words within the frame are
// dropped. Store read, column shift, products and column sums are registered;
// the final sum feeds the result queue. The first result of a frame follows
// RADIUS_TAPS*width+RADIUS_TAPS words. Stall: results queue in an 8-entry
// buffer; s_axis_tready falls only when that buffer plus results in flight
// would overflow. Reset: counters clear, geometry 640x480, default 3x3 kernel.
// The line store is not cleared; rows outside the frame are masked to zero.
`default_nettype none

module gaussian_blur_window_filter #(
  parameter int RADIUS_TAPS = 1,
  parameter int MAX_WIDTH   = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // s_axis_tdata: [7:0] pixel
  input  wire logic [7:0]                         s_axis_tdata,
  // s_axis_tuser: [0] opcode
  input  wire logic [0:0]                         s_axis_tuser,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // m_axis_tdata: [7:0] out_pixel
  output logic [7:0]                              m_axis_tdata,
  output logic                                    m_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [gbw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [gbw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int TAPS   = 2 * RADIUS_TAPS + 1;
  localparam int S      = 2 * RADIUS_TAPS + 2;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int BW     = $clog2(S);
  localparam int RW     = gbw_pkg::FH_W + 1;
  localparam int LW     = $clog2(RADIUS_TAPS * MAX_WIDTH + RADIUS_TAPS + 1);
  localparam int EW     = WW + 2;
  localparam int PW     = gbw_pkg::PIX_W + gbw_pkg::COEF_W;
  localparam int CSW    = PW + $clog2(TAPS);
  localparam int SW     = CSW + $clog2(TAPS);
  localparam int OCW    = $clog2(gbw_pkg::OUT_DEPTH + 1);
  localparam int PIX_W  = gbw_pkg::PIX_W;
  localparam int COEF_W = gbw_pkg::COEF_W;

  typedef struct packed {
    logic             adv;
    logic             emit;
    logic             last;
    logic [BW-1:0]    wrow;
    logic [PIX_W-1:0] pixel;
    logic [TAPS-1:0]  row_ok;
    logic [TAPS-1:0]  col_ok;
  } s1_t;

  typedef struct packed {
    logic            emit;
    logic            last;
    logic [TAPS-1:0] col_ok;
  } s2_t;

  typedef struct packed {
    logic emit;
    logic last;
  } stage_t;

  // Configuration registers
  logic [gbw_pkg::FW_W-1:0]       frame_width_q;
  logic [gbw_pkg::FH_W-1:0]       frame_height_q;
  logic [gbw_pkg::CFG_DATA_W-1:0] kernel_q [TAPS];
  logic                           cfg_wr;
  logic                           geom_wr;

  // Frame counters
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [BW-1:0] wrow_q, wrow_d;
  logic [LW-1:0] lead_cnt_q, lead_cnt_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;

  logic [WW-1:0]            eff_w;
  logic [gbw_pkg::FH_W-1:0] eff_h;
  logic [LW-1:0]            lead;
  logic                     acc, in_frame, adv, wr_en, emit_now, last_now;
  logic [WW-1:0]            in_col_nxt, out_col_nxt;
  logic [TAPS-1:0]          row_ok, col_ok;

  // Pipeline
  s1_t    s1_q;
  s2_t    s2_q;
  stage_t s3_q, s4_q;

  logic [PIX_W-1:0]                  bank_rdata [S];
  logic [TAPS-1:0][PIX_W-1:0]        new_col;
  logic [TAPS-1:0][PIX_W-1:0]        cell_col [TAPS];
  logic [CSW-1:0]                    cell_sum [TAPS];
  logic [TAPS-1:0][COEF_W-1:0]       cell_w   [TAPS];
  logic [SW-1:0]                     total;
  logic [SW-1:0]                     scaled;
  gbw_pkg::result_t                  res;
  gbw_pkg::result_t                  head;
  logic [OCW-1:0]                    fifo_count;
  logic [OCW:0]                      occ;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign geom_wr     = cfg_wr && (cfg_index_i == gbw_pkg::REG_FRAME_WIDTH ||
                                  cfg_index_i == gbw_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= gbw_pkg::FRAME_WIDTH_RST;
      frame_height_q <= gbw_pkg::FRAME_HEIGHT_RST;
      for (int r = 0; r < TAPS; r++) begin
        kernel_q[r] <= gbw_pkg::KERNEL_RST[r];
      end
    end else if (cfg_wr) begin
      case (cfg_index_i) inside
        gbw_pkg::REG_FRAME_WIDTH: begin
          frame_width_q <= cfg_data_i[gbw_pkg::FW_W-1:0];
        end
        gbw_pkg::REG_FRAME_HEIGHT: begin
          frame_height_q <= cfg_data_i[gbw_pkg::FH_W-1:0];
        end
        [gbw_pkg::REG_KERNEL_ROW_0:gbw_pkg::REG_KERNEL_ROW_4]: begin
          for (int r = 0; r < TAPS; r++) begin
            if (cfg_index_i == gbw_pkg::CFG_IDX_W'(gbw_pkg::REG_KERNEL_ROW_0 + r)) begin
              kernel_q[r] <= cfg_data_i;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp geometry to the usable range
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_q);
    end
    eff_h = (frame_height_q == '0) ? gbw_pkg::FH_W'(1) : frame_height_q;
    lead  = LW'(eff_w) * LW'(RADIUS_TAPS) + LW'(RADIUS_TAPS);
  end

  // ---------------------------------------------------------------- counters
  assign occ           = (OCW + 1)'(fifo_count) + (OCW + 1)'(s1_q.emit) +
                         (OCW + 1)'(s2_q.emit) + (OCW + 1)'(s3_q.emit) +
                         (OCW + 1)'(s4_q.emit);
  assign s_axis_tready = occ < (OCW + 1)'(gbw_pkg::OUT_DEPTH);

  always_comb begin
    acc         = s_axis_tvalid && s_axis_tready;
    in_frame    = in_row_q < RW'(eff_h);
    adv         = acc && (!in_frame || s_axis_tuser[0] == gbw_pkg::OP_PIXEL);
    wr_en       = acc && in_frame && s_axis_tuser[0] == gbw_pkg::OP_PIXEL;
    emit_now    = adv && (lead_cnt_q >= lead);
    in_col_nxt  = WW'(in_col_q) + 1'b1;
    out_col_nxt = WW'(out_col_q) + 1'b1;
    last_now    = emit_now && (out_row_q + 1'b1 >= RW'(eff_h)) && (out_col_nxt >= eff_w);

    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    wrow_d     = wrow_q;
    lead_cnt_d = lead_cnt_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;

    if (adv) begin
      if (in_col_nxt >= eff_w) begin
        in_col_d = '0;
        in_row_d = in_row_q + 1'b1;
        wrow_d   = (wrow_q == BW'(S - 1)) ? '0 : wrow_q + 1'b1;
      end else begin
        in_col_d = CW'(in_col_nxt);
      end
      if (!emit_now) begin
        lead_cnt_d = lead_cnt_q + 1'b1;
      end
    end

    if (emit_now) begin
      if (out_col_nxt >= eff_w) begin
        out_col_d = '0;
        out_row_d = out_row_q + 1'b1;
      end else begin
        out_col_d = CW'(out_col_nxt);
      end
    end

    // Restart the frame after its final output or on a geometry change
    if (last_now || geom_wr) begin
      in_col_d   = '0;
      in_row_d   = '0;
      wrow_d     = '0;
      lead_cnt_d = '0;
      out_col_d  = '0;
      out_row_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      wrow_q     <= '0;
      lead_cnt_q <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      wrow_q     <= wrow_d;
      lead_cnt_q <= lead_cnt_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
    end
  end

  // Row element dy of the new column is frame row in_row-2R+dy; column k of
  // the window is frame column out_col+R-k.
  always_comb begin
    for (int dy = 0; dy < TAPS; dy++) begin
      row_ok[dy] = ((RW + 1)'(in_row_q) + (RW + 1)'(dy) >= (RW + 1)'(2 * RADIUS_TAPS)) &&
                   ((RW + 1)'(in_row_q) + (RW + 1)'(dy) <
                    (RW + 1)'(eff_h) + (RW + 1)'(2 * RADIUS_TAPS));
    end
    for (int k = 0; k < TAPS; k++) begin
      col_ok[k] = (EW'(out_col_q) + EW'(RADIUS_TAPS) >= EW'(k)) &&
                  (EW'(out_col_q) + EW'(RADIUS_TAPS) < EW'(eff_w) + EW'(k));
    end
  end

  // ---------------------------------------------------------------- line store
  for (genvar b = 0; b < S; b++) begin : g_bank
    gbw_line_bank #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (wr_en && (wrow_q == BW'(b))),
      .waddr_i (in_col_q),
      .wdata_i (s_axis_tdata),
      .raddr_i (in_col_q),
      .rdata_o (bank_rdata[b])
    );
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else begin
      s1_q.adv    <= adv;
      s1_q.emit   <= emit_now;
      s1_q.last   <= last_now;
      s1_q.wrow   <= wrow_q;
      s1_q.pixel  <= s_axis_tdata;
      s1_q.row_ok <= row_ok;
      s1_q.col_ok <= col_ok;
      s2_q.emit   <= s1_q.emit;
      s2_q.last   <= s1_q.last;
      s2_q.col_ok <= s1_q.col_ok;
      s3_q.emit   <= s2_q.emit;
      s3_q.last   <= s2_q.last;
      s4_q.emit   <= s3_q.emit;
      s4_q.last   <= s3_q.last;
    end
  end

  // Build the incoming column: older rows from the banks, newest row direct
  always_comb begin
    logic [BW:0] bsel;
    bsel = '0;
    for (int dy = 0; dy < TAPS - 1; dy++) begin
      bsel = (BW + 1)'(s1_q.wrow) + (BW + 1)'(2 + dy);
      if (bsel >= (BW + 1)'(S)) begin
        bsel = bsel - (BW + 1)'(S);
      end
      new_col[dy] = s1_q.row_ok[dy] ? bank_rdata[BW'(bsel)] : '0;
    end
    new_col[TAPS-1] = s1_q.row_ok[TAPS-1] ? s1_q.pixel : '0;
  end

  // Cell k holds window column dx = 2R-k
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      for (int dy = 0; dy < TAPS; dy++) begin
        cell_w[k][dy] = kernel_q[dy][COEF_W*(TAPS-1-k) +: COEF_W];
      end
    end
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    gbw_cell #(
      .TAPS  (TAPS),
      .SUM_W (CSW)
    ) u_cell (
      .clk_i      (clk_i),
      .shift_en_i (s1_q.adv),
      .col_i      ((k == 0) ? new_col : cell_col[(k == 0) ? 0 : k - 1]),
      .col_o      (cell_col[k]),
      .weight_i   (cell_w[k]),
      .col_ok_i   (s2_q.col_ok[k]),
      .sum_o      (cell_sum[k])
    );
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < TAPS; k++) begin
      total = total + SW'(cell_sum[k]);
    end
    scaled   = total >> gbw_pkg::COEFF_FRAC_BITS;
    res.pix  = (scaled > SW'(255)) ? 8'hFF : PIX_W'(scaled);
    res.last = s4_q.last;
  end

  gbw_out_fifo #(
    .DEPTH (gbw_pkg::OUT_DEPTH),
    .CNT_W (OCW)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s4_q.emit),
    .push_data_i (res),
    .valid_o     (m_axis_tvalid),
    .data_o      (head),
    .ready_i     (m_axis_tready),
    .count_o     (fifo_count)
  );

  assign m_axis_tdata = head.pix;
  assign m_axis_tlast = head.last;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= (OCW + 1)'(gbw_pkg::OUT_DEPTH))
    else $error("result credit overrun");

  a_emit_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.emit |-> s1_q.adv)
    else $error("output without window shift");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < eff_w)
    else $error("input column beyond frame width");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_now |=> (in_row_q == '0 && in_col_q == '0 && lead_cnt_q == '0 &&
                  out_row_q == '0 && out_col_q == '0))
    else $error("counters not cleared after last word of frame");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_q.emit |-> fifo_count < OCW'(gbw_pkg::OUT_DEPTH))
    else $error("push into full result queue");
`endif

endmodule

`default_nettype wire

// ===== sv/gbw_line_bank.sv =====
// One row bank of the line store: one write port, one registered read port.
// Depends on gbw_pkg for the pixel width.
`default_nettype none

module gbw_line_bank #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [gbw_pkg::PIX_W-1:0] wdata_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [gbw_pkg::PIX_W-1:0] rdata_o
);

  logic [gbw_pkg::PIX_W-1:0] mem [DEPTH];
  logic [gbw_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/gbw_cell.sv =====
// Window column cell: holds one column of the window, passes it to the next
// cell on shift, and forms the weighted column sum. Depends on gbw_pkg.
`default_nettype none

module gbw_cell #(
  parameter int TAPS  = 3,
  parameter int SUM_W = 22
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 shift_en_i,
  input  wire logic [TAPS-1:0][gbw_pkg::PIX_W-1:0]  col_i,
  output logic      [TAPS-1:0][gbw_pkg::PIX_W-1:0]  col_o,
  input  wire logic [TAPS-1:0][gbw_pkg::COEF_W-1:0] weight_i,
  input  wire logic                                 col_ok_i,
  output logic      [SUM_W-1:0]                     sum_o
);

  localparam int PW = gbw_pkg::PIX_W + gbw_pkg::COEF_W;

  logic [TAPS-1:0][gbw_pkg::PIX_W-1:0] col_q;
  logic [TAPS-1:0][PW-1:0]             prod_d;
  logic [TAPS-1:0][PW-1:0]             prod_q;
  logic [SUM_W-1:0]                    sum_d;
  logic [SUM_W-1:0]                    sum_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      col_q <= col_i;
    end
  end

  // Drop the whole column when it lies outside the frame for this output
  always_comb begin
    for (int dy = 0; dy < TAPS; dy++) begin
      prod_d[dy] = col_ok_i ? PW'(col_q[dy]) * PW'(weight_i[dy]) : '0;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int dy = 0; dy < TAPS; dy++) begin
      sum_d = sum_d + SUM_W'(prod_q[dy]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== sv/gbw_out_fifo.sv =====
// Result queue between the arithmetic pipeline and the output stream.
// Depends on gbw_pkg for the result word type.
`default_nettype none

module gbw_out_fifo #(
  parameter int DEPTH = 8,
  parameter int CNT_W = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire gbw_pkg::result_t push_data_i,
  output logic                  valid_o,
  output gbw_pkg::result_t      data_o,
  input  wire logic             ready_i,
  output logic [CNT_W-1:0]      count_o
);

  localparam int PTR_W = $clog2(DEPTH);

  gbw_pkg::result_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             pop;

  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_blur_window_filter: streams raster frames,
// predicts each blurred pixel in a scoreboard class and compares in order.
// Depends on gbw_pkg and the gaussian_blur_window_filter RTL.

module tb;
  import gbw_pkg::*;

  localparam int RADIUS         = 1;
  localparam int MAX_W          = 1024;
  localparam int TAPS           = 2 * RADIUS + 1;
  localparam int STORE_ROWS     = 2 * RADIUS + 2;
  localparam int KROWS          = 5;
  localparam int RANDOM_WORDS   = 1050;
  localparam int CALM_WORDS     = 150;
  localparam int DRAIN_PAD      = 24;
  localparam int WATCHDOG_LIMIT = 2000;

  // Index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  class blur_tracker;
    logic [FW_W-1:0]       width_reg;
    logic [FH_W-1:0]       height_reg;
    logic [CFG_DATA_W-1:0] kernel_reg [KROWS];
    logic [7:0]            line_mem [STORE_ROWS*MAX_W];
    int unsigned           in_row, in_col, out_row, out_col;
    result_t               blurred_q [$];
    int unsigned           mismatches;

    function new();
      width_reg     = 11'd640;
      height_reg    = 13'd480;
      kernel_reg[0] = 60'd69206272;
      kernel_reg[1] = 60'd8594129408;
      kernel_reg[2] = 60'd69206272;
      kernel_reg[3] = '0;
      kernel_reg[4] = '0;
      mismatches    = 0;
      clear_position();
    endfunction

    function void clear_position();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned pending();
      return blurred_q.size();
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = val[FW_W-1:0];
          clear_position();
        end
        REG_FRAME_HEIGHT: begin
          height_reg = val[FH_W-1:0];
          clear_position();
        end
        REG_KERNEL_ROW_0, REG_KERNEL_ROW_1, REG_KERNEL_ROW_2,
        REG_KERNEL_ROW_3, REG_KERNEL_ROW_4: begin
          kernel_reg[idx - REG_KERNEL_ROW_0] = val;
        end
        default: ;
      endcase
    endfunction

    // Zero-padded weighted sum around the current output position.
    function logic [7:0] blur_value(int unsigned w, int unsigned h);
      int unsigned acc;
      int          py, px;
      logic [11:0] wt;
      acc = 0;
      for (int dy = 0; dy < TAPS; dy++) begin
        py = int'(out_row) + dy - RADIUS;
        if (py < 0 || py >= int'(h)) continue;
        for (int dx = 0; dx < TAPS; dx++) begin
          px = int'(out_col) + dx - RADIUS;
          if (px < 0 || px >= int'(w)) continue;
          wt = kernel_reg[dy][12*dx +: 12];
          acc += 32'(line_mem[(py % STORE_ROWS) * MAX_W + px]) * 32'(wt);
        end
      end
      acc = acc >> COEFF_FRAC_BITS;
      return (acc > 255) ? 8'hFF : acc[7:0];
    endfunction

    function void take_word(opcode_e op, logic [7:0] pix);
      int unsigned w, h, n, lead;
      result_t     res;
      w    = eff_w();
      h    = eff_h();
      n    = in_row * w + in_col;
      lead = RADIUS * w + RADIUS;
      if (n < w * h) begin
        // drop a drain word that comes before the frame is complete
        if (op != OP_PIXEL) return;
        line_mem[(in_row % STORE_ROWS) * MAX_W + in_col] = pix;
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (n < lead) return;
      res.pix  = blur_value(w, h);
      res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
      blurred_q.push_back(res);
      if (res.last) begin
        clear_position();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_blurred(logic [7:0] pix, logic last);
      result_t want;
      if (blurred_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: pixel %0d last %0b", pix, last);
        return;
      end
      want = blurred_q.pop_front();
      if (want.pix !== pix || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                   want.pix, pix, want.last, last);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic [7:0]            s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  blur_tracker tracker;
  bit          calm          = 1'b0;
  bit          src_gaps      = 1'b1;
  bit          sink_gaps     = 1'b1;
  int          sink_hold     = 0;
  int unsigned words_counted = 0;
  int unsigned quiet_cycles  = 0;

  gaussian_blur_window_filter #(
    .RADIUS_TAPS(RADIUS),
    .MAX_WIDTH  (MAX_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Output side back-pressure in random bursts.
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (!calm && sink_gaps && $urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(1, 8);
    end
    m_axis_tready <= (sink_hold == 0);
  end

  // Sample handshakes with pre-edge values; check before noting new input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_blurred(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_word(opcode_e'(s_axis_tuser[0]), s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_kernel_row();
    logic [CFG_DATA_W-1:0] row;
    int                    style;
    row   = '0;
    style = $urandom_range(0, 9);
    for (int k = 0; k < KROWS; k++) begin
      case (style)
        0:       row[12*k +: 12] = 12'h000;
        1:       row[12*k +: 12] = 12'hFFF;
        2, 3, 4: row[12*k +: 12] = 12'($urandom_range(0, 4095));
        default: row[12*k +: 12] = 12'($urandom_range(0, 450));
      endcase
    end
    return row;
  endfunction

  task automatic push_word(opcode_e op, logic [7:0] pix);
    if (!calm && src_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.load_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper data bits carry junk; the register keeps only its own width.
  task automatic set_geometry(int w, int h);
    logic [CFG_DATA_W-1:0] val;
    val         = CFG_DATA_W'({$urandom, $urandom});
    val[FW_W-1:0] = FW_W'(w);
    write_reg(REG_FRAME_WIDTH, val);
    val         = CFG_DATA_W'({$urandom, $urandom});
    val[FH_W-1:0] = FH_W'(h);
    write_reg(REG_FRAME_HEIGHT, val);
  endtask

  task automatic load_kernels();
    for (int k = 0; k < KROWS; k++)
      write_reg(cfg_reg_e'(REG_KERNEL_ROW_0 + k), draw_kernel_row());
  endtask

  // Hold the source, wait for every expected word, then let the pipe empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    // let the last accepted word reach the scoreboard first
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // Send a frame and its drain words, or only the first cut pixels.
  task automatic stream_frame(int cut, bit noisy);
    int w, h, npix, lead;
    w    = tracker.eff_w();
    h    = tracker.eff_h();
    npix = (cut != 0) ? cut : w * h;
    lead = RADIUS * w + RADIUS;
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) push_word(OP_DRAIN, 8'($urandom));
      push_word(OP_PIXEL, pick_pixel());
      words_counted++;
    end
    if (cut == 0) begin
      // a pixel word after the frame acts as a drain word
      for (int i = 0; i < lead; i++) begin
        push_word(($urandom_range(0, 5) == 0) ? OP_PIXEL : OP_DRAIN, 8'($urandom));
        words_counted++;
      end
    end
  endtask

  initial begin
    bit do_geo, do_kern, do_junk, restart;
    int w, h, cut;
    tracker = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry and kernel: a partial frame at width 640.
    stream_frame(660, 1'b0);
    settle();

    // 3x2 frame with early drain, late pixel and a stray drain after the end.
    set_geometry(3, 2);
    push_word(OP_PIXEL, 8'h00);
    push_word(OP_PIXEL, 8'hFF);
    push_word(OP_DRAIN, 8'hFF);
    push_word(OP_PIXEL, 8'h55);
    push_word(OP_PIXEL, 8'hAA);
    push_word(OP_PIXEL, 8'hFF);
    push_word(OP_PIXEL, 8'h01);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_PIXEL, 8'h80);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_DRAIN, 8'h00);
    settle();

    // Full-scale weights on the smallest frame; zero geometry acts as 1x1.
    for (int k = 0; k < KROWS; k++)
      write_reg(cfg_reg_e'(REG_KERNEL_ROW_0 + k), '1);
    write_reg(REG_UNMAPPED, '0);
    set_geometry(0, 0);
    push_word(OP_PIXEL, 8'hFF);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_PIXEL, 8'h7F);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_PIXEL, 8'h33);
    settle();
    for (int k = 0; k < KROWS; k++)
      write_reg(cfg_reg_e'(REG_KERNEL_ROW_0 + k), '0);
    set_geometry(1, 1);
    push_word(OP_PIXEL, 8'hFF);
    push_word(OP_DRAIN, 8'h00);
    push_word(OP_DRAIN, 8'h00);
    settle();

    // Oversized width clamps to the line store; tallest height, cut short.
    load_kernels();
    set_geometry(2047, 3);
    stream_frame(MAX_W + 60, 1'b0);
    settle();
    set_geometry(1, 8191);
    stream_frame(40, 1'b1);
    settle();

    words_counted = 0;
    restart       = 1'b1;
    while (words_counted < RANDOM_WORDS) begin
      calm      = (words_counted + CALM_WORDS >= RANDOM_WORDS);
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      do_kern   = ($urandom_range(0, 2) == 0);
      do_junk   = ($urandom_range(0, 7) == 0);
      do_geo    = restart || ($urandom_range(0, 3) != 0);
      if (do_kern || do_junk || do_geo) settle();
      if (do_kern) load_kernels();
      if (do_junk) write_reg(REG_UNMAPPED, CFG_DATA_W'({$urandom, $urandom}));
      if (do_geo) begin
        case ($urandom_range(0, 15))
          0:       w = 0;
          1:       w = 1;
          2:       w = $urandom_range(13, 48);
          default: w = $urandom_range(2, 12);
        endcase
        case ($urandom_range(0, 15))
          0:       h = 0;
          1:       h = 1;
          default: h = $urandom_range(2, 6);
        endcase
        set_geometry(w, h);
      end
      cut = 0;
      if (!calm && $urandom_range(0, 7) == 0)
        cut = $urandom_range(1, tracker.eff_w() * tracker.eff_h());
      stream_frame(cut, 1'b1);
      restart = (cut != 0);
    end
    settle();

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
